### sv/dls_pkg.sv
// Shared types, codes and the sigmoid table generator for the dense layer block.
// Used by every module of the block; depends on nothing else.

package dls_pkg;

  // Item kinds on the input channel. The fourth code is unused and ignored.
  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_ACT    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INPUTS = 2'd0;
  localparam logic [1:0] CFG_NODES  = 2'd1;

  localparam int DEF_MAX_INPUTS      = 16;
  localparam int DEF_MAX_NODES       = 16;
  localparam int DEF_SIGMOID_ENTRIES = 256;

  localparam int VAL_W = 16;
  localparam int SUM_W = 32;
  localparam int ACT_W = 13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_RUN,
    S_DRAIN,
    S_SIGA,
    S_SIGB,
    S_OUT
  } dls_state_t;

  // Sequencer commands to the shared multiply-accumulate unit.
  typedef struct packed {
    logic issue;  // operand reads were issued this cycle
    logic clear;  // load the accumulator with the bias
    logic round;  // scale and saturate the finished sum
  } mac_ctl_t;

  // Restoring long division, evaluated only while building the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // One table entry: sigmoid of z_k = -8 + k*16/entries, as unsigned Q1.12.
  function automatic logic [ACT_W-1:0] sig_entry(input int k, input int entries);
    logic [63:0] zoff;
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] a4;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    logic        neg;
    zoff = udiv64(64'(k) * 64'd65536, 64'(entries));
    neg  = (zoff < 64'd32768);
    u    = neg ? (64'd32768 - zoff) : (zoff - 64'd32768);
    // exp(-u) in Q30: Taylor series of exp(-u/256), then squared eight times.
    a  = u << 10;
    a2 = (a * a) >> 30;
    a3 = (a2 * a) >> 30;
    a4 = (a3 * a) >> 30;
    e  = 64'd1073741824 - a;
    e  = e + (a2 >> 1);
    e  = e - (a3 / 64'd6);
    e  = e + (a4 / 64'd24);
    for (int i = 0; i < 8; i++) begin
      e = (e * e) >> 30;
    end
    d = 64'd1073741824 + e;
    s = udiv64((64'd1 << 42) + (d >> 1), d);
    return neg ? ACT_W'(64'd4096 - s) : ACT_W'(s);
  endfunction

endpackage

### sv/dls_store.sv
// Weight, bias and activation memories of the dense layer block.
// Single write port per memory, registered reads; uses dls_pkg.

module dls_store import dls_pkg::*; #(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int MAX_NODES  = DEF_MAX_NODES,
  localparam int IDX_W     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                    clk,
  input  logic                    wr_weight,
  input  logic                    wr_bias,
  input  logic                    wr_act,
  input  logic [NODE_W-1:0]       wr_node,
  input  logic [IDX_W-1:0]        wr_idx,
  input  logic signed [VAL_W-1:0] wr_value,
  input  logic [NODE_W-1:0]       rd_node,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic signed [VAL_W-1:0] weight_q,
  output logic signed [VAL_W-1:0] bias_q,
  output logic signed [VAL_W-1:0] act_q
);

  localparam int DEPTH   = MAX_INPUTS * MAX_NODES;
  localparam int WADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [VAL_W-1:0] weight_mem [DEPTH];
  logic signed [VAL_W-1:0] bias_mem   [MAX_NODES];
  logic signed [VAL_W-1:0] act_mem    [MAX_INPUTS];

  logic [WADDR_W-1:0] wr_waddr;
  logic [WADDR_W-1:0] rd_waddr;

  // Weights are laid out row by row, one row of MAX_INPUTS per node.
  assign wr_waddr = WADDR_W'(wr_node) * WADDR_W'(MAX_INPUTS) + WADDR_W'(wr_idx);
  assign rd_waddr = WADDR_W'(rd_node) * WADDR_W'(MAX_INPUTS) + WADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (wr_weight) begin
      weight_mem[wr_waddr] <= wr_value;
    end
    if (wr_bias) begin
      bias_mem[wr_node] <= wr_value;
    end
    if (wr_act) begin
      act_mem[wr_idx] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    weight_q <= weight_mem[rd_waddr];
    bias_q   <= bias_mem[rd_node];
    act_q    <= act_mem[rd_idx];
  end

endmodule

### sv/dls_mac.sv
// Shared multiply-accumulate unit: one product per cycle, bias preload,
// then floor scaling by 2^12, saturated to 32 bits if wider. Uses dls_pkg.

module dls_mac import dls_pkg::*; #(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  localparam int ACC_W     = 31 + $clog2(MAX_INPUTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] weight_q,
  input  logic signed [VAL_W-1:0] bias_q,
  input  logic signed [VAL_W-1:0] act_q,
  output logic                    busy,
  output logic signed [SUM_W-1:0] sum_q
);

  localparam int SH_W = ACC_W - 12;

  logic                      iss_d_r;
  logic                      mul_vld_r;
  logic signed [2*VAL_W-1:0] mul_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SH_W-1:0]    sh;
  logic signed [SUM_W-1:0]   sat;
  logic signed [SUM_W-1:0]   sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_d_r   <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      iss_d_r   <= ctl.issue;
      mul_vld_r <= iss_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_d_r) begin
      mul_r <= act_q * weight_q;
    end
    if (ctl.clear) begin
      acc_r <= {{(ACC_W - VAL_W - 12){bias_q[VAL_W-1]}}, bias_q, 12'b0};
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
    if (ctl.round) begin
      sum_r <= sat;
    end
  end

  // Arithmetic shift gives rounding toward minus infinity.
  assign sh = acc_r[ACC_W-1:12];

  generate
    if (SH_W > SUM_W) begin : g_sat
      localparam logic signed [SH_W-1:0] ZMAX = SH_W'(32'sh7fff_ffff);
      localparam logic signed [SH_W-1:0] ZMIN = SH_W'(32'sh8000_0000);
      always_comb begin
        if (sh > ZMAX) begin
          sat = 32'sh7fff_ffff;
        end else if (sh < ZMIN) begin
          sat = 32'sh8000_0000;
        end else begin
          sat = SUM_W'(sh);
        end
      end
    end else begin : g_nosat
      assign sat = SUM_W'(sh);
    end
  endgenerate

  assign busy  = iss_d_r | mul_vld_r;
  assign sum_q = sum_r;

endmodule

### sv/dls_sigmoid.sv
// Sigmoid lookup: clip the sum to [-8,8), scale to a table index and read a
// constant table built at elaboration. Two register stages; uses dls_pkg.

module dls_sigmoid import dls_pkg::*; #(
  parameter int SIGMOID_ENTRIES = DEF_SIGMOID_ENTRIES
) (
  input  logic                    clk,
  input  logic signed [SUM_W-1:0] sum_q,
  output logic [ACT_W-1:0]        act_q
);

  localparam int SIG_W  = $clog2(SIGMOID_ENTRIES);
  localparam int PROD_W = 16 + $clog2(SIGMOID_ENTRIES + 1);

  logic [ACT_W-1:0]       sig_rom [SIGMOID_ENTRIES];
  logic signed [15:0]     off;
  logic [15:0]            off_u;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-17:0]     idx_wide;
  logic [SIG_W-1:0]       idx;
  logic [SIG_W-1:0]       idx_r;
  logic [ACT_W-1:0]       act_r;

  generate
    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
      localparam logic [ACT_W-1:0] ENTRY = sig_entry(k, SIGMOID_ENTRIES);
      assign sig_rom[k] = ENTRY;
    end
  endgenerate

  always_comb begin
    if (sum_q > 32'sd32767) begin
      off = 16'sh7fff;
    end else if (sum_q < -32'sd32768) begin
      off = 16'sh8000;
    end else begin
      off = 16'(sum_q);
    end
    // Offset by +8.0 turns the clipped value into an unsigned fraction of the range.
    off_u    = {~off[15], off[14:0]};
    prod     = PROD_W'(off_u) * PROD_W'(SIGMOID_ENTRIES);
    idx_wide = prod[PROD_W-1:16];
    if (32'(idx_wide) >= SIGMOID_ENTRIES) begin
      idx = SIG_W'(SIGMOID_ENTRIES - 1);
    end else begin
      idx = SIG_W'(idx_wide);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx;
    act_r <= sig_rom[idx_r];
  end

  assign act_q = act_r;

endmodule

### sv/dense_layer_sigmoid.sv
// Top level of the dense layer with sigmoid activation: sequencer, config
// registers and ports. Depends on dls_pkg, dls_store, dls_mac and dls_sigmoid.
//
// Usage. The input channel (in_valid/in_stall) carries one item per transfer:
// kind 0 writes a weight at (node_index, input_index), kind 1 writes the bias
// of node_index, kind 2 stores an activation at input_index. Weight, bias and
// plain activation items are stored without stalling. The activation at index
// inputs_in_use-1 starts an evaluation: the block then runs every node from 0
// to nodes_in_use-1 through one shared multiply-accumulate unit, one product
// per cycle, and offers one result per node on the output channel
// (out_valid/out_stall), with out_last set on the final node.
// For each node the sequencer reads the bias, issues one product per input in
// use, drains the read/multiply/add pipeline, reads the sigmoid table and
// transfers the result. in_stall stays high from the starting activation
// until the last result has been transferred.
// A stalled result simply holds in the output registers; the sequencer waits.
// Reset returns the sequencer to idle and sets both counts to 16; the stored
// weights, biases and activations are not cleared and must be written first.
// Configuration (cfg_valid/cfg_ready, always ready) may be written only while
// the block is idle.

module dense_layer_sigmoid import dls_pkg::*; #(
  parameter int MAX_INPUTS      = DEF_MAX_INPUTS,
  parameter int MAX_NODES       = DEF_MAX_NODES,
  parameter int SIGMOID_ENTRIES = DEF_SIGMOID_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [4:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  input  logic [3:0]              in_node_index,
  input  logic [3:0]              in_input_index,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_node,
  output logic signed [SUM_W-1:0] out_weighted_sum,
  output logic [ACT_W-1:0]        out_activation,
  output logic                    out_last
);

  localparam int IDX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  dls_state_t        state_r, state_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [4:0]        inputs_in_use_r;
  logic [4:0]        nodes_in_use_r;

  logic [IDX_W-1:0]  last_in;
  logic [NODE_W-1:0] last_node;
  logic              in_accept;
  logic              node_ok;
  logic              idx_ok;
  logic              trigger;
  mac_ctl_t          mac_ctl;
  logic              mac_busy;

  logic signed [VAL_W-1:0] weight_q;
  logic signed [VAL_W-1:0] bias_q;
  logic signed [VAL_W-1:0] act_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [ACT_W-1:0]        sig_q;

  // Configuration registers; writes beyond the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inputs_in_use_r <= 5'd16;
      nodes_in_use_r  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INPUTS) begin
        inputs_in_use_r <= cfg_data;
      end else if (cfg_index == CFG_NODES) begin
        nodes_in_use_r <= cfg_data;
      end
    end
  end

  // Counts are clamped into [1, max]; a count of zero acts as one.
  always_comb begin
    if (inputs_in_use_r == 5'd0) begin
      last_in = '0;
    end else if (32'(inputs_in_use_r) > MAX_INPUTS) begin
      last_in = IDX_W'(MAX_INPUTS - 1);
    end else begin
      last_in = IDX_W'(inputs_in_use_r - 5'd1);
    end
    if (nodes_in_use_r == 5'd0) begin
      last_node = '0;
    end else if (32'(nodes_in_use_r) > MAX_NODES) begin
      last_node = NODE_W'(MAX_NODES - 1);
    end else begin
      last_node = NODE_W'(nodes_in_use_r - 5'd1);
    end
  end

  // Input decode. Out-of-range indexes and the unused kind are ignored.
  assign in_accept = in_valid && !in_stall;
  assign node_ok   = 32'(in_node_index) < MAX_NODES;
  assign idx_ok    = 32'(in_input_index) < MAX_INPUTS;
  assign trigger   = in_accept && (in_kind == KIND_ACT) && idx_ok &&
                     (IDX_W'(in_input_index) == last_in);

  dls_store #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_NODES  (MAX_NODES)
  ) u_store (
    .clk       (clk),
    .wr_weight (in_accept && (in_kind == KIND_WEIGHT) && node_ok && idx_ok),
    .wr_bias   (in_accept && (in_kind == KIND_BIAS) && node_ok),
    .wr_act    (in_accept && (in_kind == KIND_ACT) && idx_ok),
    .wr_node   (NODE_W'(in_node_index)),
    .wr_idx    (IDX_W'(in_input_index)),
    .wr_value  (in_value),
    .rd_node   (node_r),
    .rd_idx    (j_r),
    .weight_q  (weight_q),
    .bias_q    (bias_q),
    .act_q     (act_q)
  );

  dls_mac #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .weight_q (weight_q),
    .bias_q   (bias_q),
    .act_q    (act_q),
    .busy     (mac_busy),
    .sum_q    (sum_q)
  );

  dls_sigmoid #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_sigmoid (
    .clk   (clk),
    .sum_q (sum_q),
    .act_q (sig_q)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_r  <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      node_r  <= node_nxt;
      j_r     <= j_nxt;
    end
  end

  // The bias read for a node is addressed by node_r, so the pass through S_BIAS
  // lets it settle before the first product is issued in S_RUN.
  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    j_nxt     = j_r;
    mac_ctl   = '0;
    case (state_r)
      S_IDLE: begin
        if (trigger) begin
          state_nxt = S_BIAS;
          node_nxt  = '0;
          j_nxt     = '0;
        end
      end
      S_BIAS: begin
        state_nxt = S_RUN;
        j_nxt     = '0;
      end
      S_RUN: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = (j_r == '0);
        if (j_r == last_in) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          mac_ctl.round = 1'b1;
          state_nxt     = S_SIGA;
        end
      end
      S_SIGA: begin
        state_nxt = S_SIGB;
      end
      S_SIGB: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (node_r == last_node) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_BIAS;
            node_nxt  = node_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // Results come straight from registers that hold still in S_OUT.
  assign out_valid        = (state_r == S_OUT);
  assign out_node         = 4'(node_r);
  assign out_weighted_sum = sum_q;
  assign out_activation   = sig_q;
  assign out_last         = (node_r == last_node);

  // A result is shown only after the accumulator pipeline has emptied.
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !mac_busy)
    else $error("result offered while products are still in flight");

  // The starting activation always opens an evaluation at the bias read.
  a_trigger_starts: assert property (@(posedge clk) disable iff (!rst_n)
    trigger |=> (state_r == S_BIAS) && (node_r == '0))
    else $error("evaluation did not start after the final activation");

  // The transfer of the final node's result returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (state_r == S_IDLE))
    else $error("block did not return to idle after the last result");

  // The product index never runs past the number of inputs in use.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (j_r <= last_in))
    else $error("input index ran beyond inputs in use");

endmodule
